// ===== sv/trilinear_volume_sampler_top_macros.svh =====
// ---------------------------------------------------------------------------
// Trilinear volume sampler assertion macros
// Concurrent checks used by the top level, empty when synthesizing.
// ---------------------------------------------------------------------------
`ifndef TRILINEAR_VOLUME_SAMPLER_TOP_MACROS_SVH
`define TRILINEAR_VOLUME_SAMPLER_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define TVS_ASSERT_IMP(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("tvs implication check failed");
`define TVS_ASSERT_NEVER(lbl, clk, rst, a) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(a)) \
    else $error("tvs exclusion check failed");
`else
`define TVS_ASSERT_IMP(lbl, clk, rst, a, c)
`define TVS_ASSERT_NEVER(lbl, clk, rst, a)
`endif
`endif

// ===== sv/tvs_pkg.sv =====
// ---------------------------------------------------------------------------
// Trilinear volume sampler package
// Shared widths, defaults and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none
package tvs_pkg;
  localparam int MAX_DIM_DEF     = 64;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int COORD_FRAC_DEF  = 16;
  localparam int RES_BITS        = 7;
  localparam int ADDR_BITS       = 18;
  localparam int VALUE_BITS      = 16;
  localparam int COORD_BITS      = 17;
  localparam int CFG_IDX_BITS    = 2;
  localparam int N_CORNER        = 8;
  localparam int PIPE_LAT        = 9;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES_X = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES_Y = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RES_Z = 2'd2;
  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;
endpackage
`default_nettype wire

// ===== sv/trilinear_volume_sampler_top.sv =====
// ---------------------------------------------------------------------------
// Trilinear volume sampler
// Grid store with a nine-stage trilinear sampling pipeline.
// ---------------------------------------------------------------------------
// Input items enter on start while busy is low; busy never rises, so one item
// can enter every cycle. func low writes voxel_value at voxel_addr and gives
// no result; func high samples at coord_u/v/w.
// A sample item's result shows on sample_value with done high for one cycle,
// once the item has left the pipeline. Throughput is one item per cycle, set
// by the fully pipelined axis multipliers, eight-copy store and lerp stages.
// Writes reach the store at the same stage where samples read it, so every
// sample sees exactly the writes taken before it.
// Configuration: cfg_we writes res_x, res_y or res_z (cfg_index 0..2) at once;
// write it only with the pipeline empty.
// Reset clears the pipeline and sets all resolutions to 64; the store keeps
// its contents and must be written before it is sampled.
// The receiver cannot stall: each result is valid for its single cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "trilinear_volume_sampler_top_macros.svh"
module trilinear_volume_sampler_top import tvs_pkg::*; #(
  parameter int MAX_DIM         = MAX_DIM_DEF,
  parameter int SAMPLE_BITS     = SAMPLE_BITS_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_DEF
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic                    func,
  input  wire logic [$clog2(MAX_DIM**3)-1:0] voxel_addr,
  input  wire logic signed [SAMPLE_BITS-1:0] voxel_value,
  input  wire logic [COORD_FRAC_BITS:0] coord_u,
  input  wire logic [COORD_FRAC_BITS:0] coord_v,
  input  wire logic [COORD_FRAC_BITS:0] coord_w,
  output logic                         done,
  output logic signed [SAMPLE_BITS-1:0] sample_value,
  input  wire logic                    cfg_we,
  input  wire logic [CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] cfg_data
);
  localparam int SB    = SAMPLE_BITS;
  localparam int CF    = COORD_FRAC_BITS;
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int IW    = $clog2(MAX_DIM);
  localparam int DEPTH = MAX_DIM ** 3;
  localparam int AW    = $clog2(DEPTH);

  logic [DW-1:0]       res_x, res_y, res_z;
  logic [DW-1:0]       rm_x, rm_y, rm_z, rx_eff;
  logic [2*DW-1:0]     rxy;

  logic [PIPE_LAT-1:0] smp;
  logic [4:0]          wr;
  logic [AW-1:0]       wa [5];
  logic [SB-1:0]       wd [5];
  logic [CF:0]         cu, cv, cw;

  logic [IW-1:0] x0, x1, y0, y1, z0, z1;
  logic [CF-1:0] fx, fy, fz;
  logic [CF-1:0] fx3, fy3, fz3, fx4, fy4, fz4, fx5, fy5, fz5, fy6, fz6, fz7;
  logic [AW-1:0] zo0, zo1, yo0, yo1;
  logic [IW-1:0] x0_3, x1_3;
  logic [N_CORNER-1:0][AW-1:0] raddr;
  logic [N_CORNER-1:0][SB-1:0] rdata;
  logic [SB-1:0] v00, v10, v01, v11, v0, v1, r;
  logic          wr_ok;
  logic [AW-1:0] waddr;
  logic [SB-1:0] wdata;
  logic [31:0]   wa_ext;

  function automatic logic [DW-1:0] eff_res(input logic [DW-1:0] rv);
    logic [31:0] e;
    e = 32'(rv);
    if (e < 32'd2) e = 32'd2;
    if (e > 32'(MAX_DIM)) e = 32'(MAX_DIM);
    return e[DW-1:0];
  endfunction

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_x <= DW'(MAX_DIM);
      res_y <= DW'(MAX_DIM);
      res_z <= DW'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_RES_X: res_x <= cfg_data;
        CFG_RES_Y: res_y <= cfg_data;
        CFG_RES_Z: res_z <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    rx_eff <= eff_res(res_x);
    rm_x <= eff_res(res_x) - DW'(1);
    rm_y <= eff_res(res_y) - DW'(1);
    rm_z <= eff_res(res_z) - DW'(1);
    rxy <= (2*DW)'(rx_eff * eff_res(res_y));
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      smp <= '0;
      wr <= '0;
    end else begin
      smp <= {smp[PIPE_LAT-2:0], start && !busy && func == FUNC_SAMPLE};
      wr <= {wr[3:0], start && !busy && func == FUNC_WRITE};
    end
  end

  always_ff @(posedge clk) begin
    cu <= coord_u;
    cv <= coord_v;
    cw <= coord_w;
    wa[0] <= voxel_addr;
    wd[0] <= voxel_value;
    for (int i = 1; i < 5; i++) begin
      wa[i] <= wa[i-1];
      wd[i] <= wd[i-1];
    end
  end

  tvs_axis #(.MAX_DIM(MAX_DIM), .COORD_FRAC(CF)) u_ax (
    .clk(clk), .c(cu), .rm(rm_x), .lo(x0), .hi(x1), .fr(fx));
  tvs_axis #(.MAX_DIM(MAX_DIM), .COORD_FRAC(CF)) u_ay (
    .clk(clk), .c(cv), .rm(rm_y), .lo(y0), .hi(y1), .fr(fy));
  tvs_axis #(.MAX_DIM(MAX_DIM), .COORD_FRAC(CF)) u_az (
    .clk(clk), .c(cw), .rm(rm_z), .lo(z0), .hi(z1), .fr(fz));

  always_ff @(posedge clk) begin
    zo0 <= AW'(z0 * rxy);
    zo1 <= AW'(z1 * rxy);
    yo0 <= AW'(y0 * rx_eff);
    yo1 <= AW'(y1 * rx_eff);
    x0_3 <= x0;
    x1_3 <= x1;
    fx3 <= fx; fy3 <= fy; fz3 <= fz;
    for (int k = 0; k < N_CORNER; k++) begin
      raddr[k] <= ((k & 4) != 0 ? zo1 : zo0) + ((k & 2) != 0 ? yo1 : yo0)
                + AW'((k & 1) != 0 ? x1_3 : x0_3);
    end
    fx4 <= fx3; fy4 <= fy3; fz4 <= fz3;
    fx5 <= fx4; fy5 <= fy4; fz5 <= fz4;
    fy6 <= fy5; fz6 <= fz5;
    fz7 <= fz6;
  end

  always_comb begin
    wa_ext = 32'(wa[4]);
    wr_ok = wr[4] && (wa_ext < 32'(DEPTH));
    waddr = wa_ext[AW-1:0];
    wdata = wd[4];
  end

  tvs_store #(.DEPTH(DEPTH), .SB(SB)) u_store (
    .clk(clk), .we(wr_ok), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata));

  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_l00 (
    .clk(clk), .a(rdata[0]), .b(rdata[1]), .f(fx5), .q(v00));
  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_l10 (
    .clk(clk), .a(rdata[2]), .b(rdata[3]), .f(fx5), .q(v10));
  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_l01 (
    .clk(clk), .a(rdata[4]), .b(rdata[5]), .f(fx5), .q(v01));
  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_l11 (
    .clk(clk), .a(rdata[6]), .b(rdata[7]), .f(fx5), .q(v11));
  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_l0 (
    .clk(clk), .a(v00), .b(v10), .f(fy6), .q(v0));
  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_l1 (
    .clk(clk), .a(v01), .b(v11), .f(fy6), .q(v1));
  tvs_lerp #(.SB(SB), .COORD_FRAC(CF)) u_lz (
    .clk(clk), .a(v0), .b(v1), .f(fz7), .q(r));

  always_comb begin
    sample_value = r;
    done = smp[PIPE_LAT-1];
  end

  `TVS_ASSERT_IMP(a_done_latency, clk, rst, done, $past(start && func == FUNC_SAMPLE, PIPE_LAT))
  `TVS_ASSERT_NEVER(a_wr_smp_excl, clk, rst, wr[4] && smp[4])
  `TVS_ASSERT_IMP(a_write_no_result, clk, rst, wr[0], !smp[0])
endmodule
`default_nettype wire

// ===== sv/tvs_axis.sv =====
// ---------------------------------------------------------------------------
// Axis split
// Clamps one coordinate, scales it by resolution minus one and splits it
// into lower cell, upper cell and fraction over two register stages.
// ---------------------------------------------------------------------------
`default_nettype none
module tvs_axis import tvs_pkg::*; #(
  parameter int MAX_DIM    = MAX_DIM_DEF,
  parameter int COORD_FRAC = COORD_FRAC_DEF
) (
  input  wire logic                         clk,
  input  wire logic [COORD_FRAC:0]          c,
  input  wire logic [$clog2(MAX_DIM+1)-1:0] rm,
  output logic [$clog2(MAX_DIM)-1:0]        lo,
  output logic [$clog2(MAX_DIM)-1:0]        hi,
  output logic [COORD_FRAC-1:0]             fr
);
  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int IW = $clog2(MAX_DIM);
  localparam int EW = COORD_FRAC + 1;
  localparam int PW = COORD_FRAC + 1 + DW;
  localparam logic [EW-1:0] ONE = EW'(1) << COORD_FRAC;

  logic [EW-1:0]         c_ext;
  logic [COORD_FRAC:0]   cc;
  logic [PW-1:0]         pos;
  logic [DW:0]           lo_raw;
  logic [DW-1:0]         lo_cl;
  logic [DW:0]           lo_inc;

  always_comb begin
    c_ext = EW'(c);
    cc = (c_ext > ONE) ? ONE[COORD_FRAC:0] : c_ext[COORD_FRAC:0];
    lo_raw = pos[PW-1:COORD_FRAC];
    lo_cl = (lo_raw > {1'b0, rm}) ? rm : lo_raw[DW-1:0];
    lo_inc = {1'b0, lo_cl} + (DW+1)'(1);
  end

  always_ff @(posedge clk) begin
    pos <= PW'(cc * rm);
    lo <= lo_cl[IW-1:0];
    hi <= (lo_inc < {1'b0, rm}) ? lo_inc[IW-1:0] : rm[IW-1:0];
    fr <= pos[COORD_FRAC-1:0];
  end
endmodule
`default_nettype wire

// ===== sv/tvs_store.sv =====
// ---------------------------------------------------------------------------
// Voxel store
// Eight copies of the grid, one per corner, all written together and each
// read at its own corner address with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none
module tvs_store import tvs_pkg::*; #(
  parameter int DEPTH = MAX_DIM_DEF ** 3,
  parameter int SB    = SAMPLE_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [$clog2(DEPTH)-1:0]             waddr,
  input  wire logic [SB-1:0]                        wdata,
  input  wire logic [N_CORNER-1:0][$clog2(DEPTH)-1:0] raddr,
  output logic      [N_CORNER-1:0][SB-1:0]          rdata
);
  for (genvar k = 0; k < N_CORNER; k++) begin : g_copy
    logic [SB-1:0] mem [DEPTH];
    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata[k] <= mem[raddr[k]];
    end
  end
endmodule
`default_nettype wire

// ===== sv/tvs_lerp.sv =====
// ---------------------------------------------------------------------------
// Lerp stage
// Registered a + (b - a) * f with round half up.
// ---------------------------------------------------------------------------
`default_nettype none
module tvs_lerp import tvs_pkg::*; #(
  parameter int SB         = SAMPLE_BITS_DEF,
  parameter int COORD_FRAC = COORD_FRAC_DEF
) (
  input  wire logic                  clk,
  input  wire logic [SB-1:0]         a,
  input  wire logic [SB-1:0]         b,
  input  wire logic [COORD_FRAC-1:0] f,
  output logic [SB-1:0]              q
);
  localparam int TW = SB + COORD_FRAC + 3;
  localparam logic [TW-1:0] HALF = TW'(1) << (COORD_FRAC - 1);

  logic signed [SB:0]            d;
  logic signed [COORD_FRAC:0]    fs;
  logic signed [SB+COORD_FRAC+1:0] prod;
  logic [TW-1:0]                 t;

  always_comb begin
    d = {b[SB-1], b} - {a[SB-1], a};
    fs = {1'b0, f};
    prod = d * fs;
    t = {{3{a[SB-1]}}, a, {COORD_FRAC{1'b0}}} + {prod[SB+COORD_FRAC+1], prod} + HALF;
  end

  always_ff @(posedge clk) begin
    q <= t[COORD_FRAC+SB-1:COORD_FRAC];
  end
endmodule
`default_nettype wire

// ===== sim/trilinear_volume_sampler_top_test.sv =====
// ---------------------------------------------------------------------------
// Trilinear volume sampler testbench
// Loads small voxel grids under several resolution settings, including the
// saturating ones, then streams random sample items and noise writes with
// random gaps. Each sample result is checked against a fixed-point trilinear
// blend of the grid kept in the testbench.
// ---------------------------------------------------------------------------
`default_nettype none
module trilinear_volume_sampler_top_test import tvs_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_ONE = 1 << COORD_FRAC_DEF;
  localparam int unsigned DEPTH     = MAX_DIM_DEF * MAX_DIM_DEF * MAX_DIM_DEF;
  localparam int          STALL_MAX = 400;

  class sample_scoreboard;
    logic signed [VALUE_BITS-1:0] grid [DEPTH];
    logic signed [VALUE_BITS-1:0] pending [$];
    int unsigned rx, ry, rz;
    int errors, samples_seen, writes_seen;

    function new();
      rx = MAX_DIM_DEF;
      ry = MAX_DIM_DEF;
      rz = MAX_DIM_DEF;
    endfunction

    function void set_res(logic [CFG_IDX_BITS-1:0] idx, logic [RES_BITS-1:0] d);
      int unsigned r;
      r = (d < 2) ? 2 : ((d > MAX_DIM_DEF) ? MAX_DIM_DEF : d);
      case (idx)
        CFG_RES_X: rx = r;
        CFG_RES_Y: ry = r;
        CFG_RES_Z: rz = r;
        default: ;
      endcase
    endfunction

    function logic signed [VALUE_BITS-1:0] blend(logic signed [VALUE_BITS-1:0] a,
                                                 logic signed [VALUE_BITS-1:0] b,
                                                 int unsigned f);
      longint t;
      t = longint'(a) * longint'(COORD_ONE - f) + longint'(b) * longint'(f)
          + longint'(COORD_ONE / 2);
      return VALUE_BITS'(t >>> COORD_FRAC_DEF);
    endfunction

    function void split(int unsigned c, int unsigned r,
                        output int unsigned lo, output int unsigned hi,
                        output int unsigned fr);
      longint unsigned pos;
      if (c > COORD_ONE) c = COORD_ONE;
      pos = longint'(c) * (r - 1);
      lo = pos >> COORD_FRAC_DEF;
      fr = pos & (COORD_ONE - 1);
      if (lo > r - 1) lo = r - 1;
      hi = (lo + 1 < r - 1) ? lo + 1 : r - 1;
    endfunction

    function logic signed [VALUE_BITS-1:0] voxel(int unsigned x, int unsigned y,
                                                 int unsigned z);
      return grid[z * ry * rx + y * rx + x];
    endfunction

    function void note_item(logic fn, logic [ADDR_BITS-1:0] addr,
                            logic signed [VALUE_BITS-1:0] val,
                            logic [COORD_BITS-1:0] u, logic [COORD_BITS-1:0] v,
                            logic [COORD_BITS-1:0] w);
      int unsigned x0, x1, y0, y1, z0, z1, fx, fy, fz;
      logic signed [VALUE_BITS-1:0] a00, a10, a01, a11, b0, b1;
      if (fn == FUNC_WRITE) begin
        grid[addr] = val;
        writes_seen++;
        return;
      end
      split(u, rx, x0, x1, fx);
      split(v, ry, y0, y1, fy);
      split(w, rz, z0, z1, fz);
      a00 = blend(voxel(x0, y0, z0), voxel(x1, y0, z0), fx);
      a10 = blend(voxel(x0, y1, z0), voxel(x1, y1, z0), fx);
      a01 = blend(voxel(x0, y0, z1), voxel(x1, y0, z1), fx);
      a11 = blend(voxel(x0, y1, z1), voxel(x1, y1, z1), fx);
      b0 = blend(a00, a10, fy);
      b1 = blend(a01, a11, fy);
      pending.push_back(blend(b0, b1, fz));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [VALUE_BITS-1:0] got);
      logic signed [VALUE_BITS-1:0] want;
      if (pending.size() == 0) begin
        report($sformatf("sample_value %0d with no sample pending", got));
        return;
      end
      want = pending.pop_front();
      samples_seen++;
      if (got !== want)
        report($sformatf("sample_value %0d, expected %0d", got, want));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic func = FUNC_WRITE;
  logic [ADDR_BITS-1:0] voxel_addr = '0;
  logic signed [VALUE_BITS-1:0] voxel_value = '0;
  logic [COORD_BITS-1:0] coord_u = '0;
  logic [COORD_BITS-1:0] coord_v = '0;
  logic [COORD_BITS-1:0] coord_w = '0;
  logic done;
  logic signed [VALUE_BITS-1:0] sample_value;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_index = CFG_RES_X;
  logic [RES_BITS-1:0] cfg_data = '0;

  sample_scoreboard sb = new();
  int stall_cycles = 0;
  int phases = 0;

  trilinear_volume_sampler_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .func(func),
    .voxel_addr(voxel_addr), .voxel_value(voxel_value),
    .coord_u(coord_u), .coord_v(coord_v), .coord_w(coord_w),
    .done(done), .sample_value(sample_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(sample_value);
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_MAX) begin
      $display("timeout: no item moved for %0d cycles", STALL_MAX);
      $display("CHECK FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  function logic [COORD_BITS-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return COORD_BITS'(COORD_ONE);
      2: return COORD_BITS'($urandom_range(COORD_ONE + 1, (1 << COORD_BITS) - 1));
      default: return COORD_BITS'($urandom_range(0, COORD_ONE - 1));
    endcase
  endfunction

  function logic signed [VALUE_BITS-1:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  task send(logic fn, logic [ADDR_BITS-1:0] addr, logic signed [VALUE_BITS-1:0] val,
            logic [COORD_BITS-1:0] u, logic [COORD_BITS-1:0] v,
            logic [COORD_BITS-1:0] w, int gap);
    start <= 1'b1;
    func <= fn;
    voxel_addr <= addr;
    voxel_value <= val;
    coord_u <= u;
    coord_v <= v;
    coord_w <= w;
    do @(posedge clk); while (busy);
    sb.note_item(fn, addr, val, u, v, w);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task write_voxel(int unsigned addr, logic signed [VALUE_BITS-1:0] val);
    send(FUNC_WRITE, ADDR_BITS'(addr), val, pick_coord(), pick_coord(), pick_coord(),
         pick_gap());
  endtask

  task sample_at(logic [COORD_BITS-1:0] u, logic [COORD_BITS-1:0] v,
                 logic [COORD_BITS-1:0] w);
    send(FUNC_SAMPLE, ADDR_BITS'($urandom), pick_value(), u, v, w, pick_gap());
  endtask

  task drain();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (PIPE_LAT + 2) @(posedge clk);
  endtask

  task write_cfg(logic [CFG_IDX_BITS-1:0] idx, logic [RES_BITS-1:0] d);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    sb.set_res(idx, d);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task set_grid(logic [RES_BITS-1:0] x, logic [RES_BITS-1:0] y, logic [RES_BITS-1:0] z);
    drain();
    write_cfg(CFG_RES_X, x);
    write_cfg(CFG_RES_Y, y);
    write_cfg(CFG_RES_Z, z);
    phases++;
  endtask

  task fill_grid();
    for (int unsigned i = 0; i < sb.rx * sb.ry * sb.rz; i++)
      write_voxel(i, pick_value());
  endtask

  task random_traffic(int n);
    int unsigned cells;
    cells = sb.rx * sb.ry * sb.rz;
    repeat (n) begin
      case ($urandom_range(0, 19))
        0, 1, 2: write_voxel($urandom_range(0, cells - 1), pick_value());
        3:       write_voxel($urandom_range(cells, DEPTH - 1), pick_value());
        default: sample_at(pick_coord(), pick_coord(), pick_coord());
      endcase
    end
  endtask

  initial begin
    logic signed [VALUE_BITS-1:0] corners [8];
    corners = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1,
                16'sh7fff, 16'sh8000, 16'sd256, -16'sd256};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: unit cube with extreme samples, ignored index, saturating coords
    set_grid(7'd2, 7'd2, 7'd2);
    write_cfg(2'd3, 7'd0);
    foreach (corners[i]) write_voxel(i, corners[i]);
    sample_at('0, '0, '0);
    sample_at(17'd65536, 17'd65536, 17'd65536);
    sample_at(17'h1ffff, 17'h1ffff, 17'h1ffff);
    sample_at(17'd32768, 17'd32768, 17'd32768);
    sample_at(17'd32768, '0, '0);
    sample_at(17'd65535, 17'd1, 17'd65535);
    sample_at(17'd1, 17'd65535, 17'd32768);
    sample_at(17'd16384, 17'd49152, 17'd65537);
    write_voxel(262143, 16'sh7fff);
    sample_at(17'd12345, 17'd54321, 17'd40000);

    // saturating register values with x and then z at full size
    set_grid(7'd127, 7'd1, 7'd0);
    fill_grid();
    random_traffic(40);
    set_grid(7'd1, 7'd0, 7'd127);
    fill_grid();
    random_traffic(40);

    repeat (2) begin
      set_grid(RES_BITS'($urandom_range(2, 5)), RES_BITS'($urandom_range(2, 5)),
               RES_BITS'($urandom_range(2, 5)));
      fill_grid();
      random_traffic(40);
    end

    drain();
    repeat (PIPE_LAT + 5) @(posedge clk);
    while (sb.pending.size() != 0) begin
      sb.report("sample result never arrived");
      void'(sb.pending.pop_front());
    end
    $display("covered %0d grid settings, %0d voxel writes, %0d samples checked",
             phases, sb.writes_seen, sb.samples_seen);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
